// ===== src/spq_pkg.sv =====
// Shared types, constants and codes for the stable priority queue.
package spq_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned CountW     = $clog2(QueueDepth + 1);

  localparam int unsigned TagW   = 16;
  localparam int unsigned AgeW   = 7;
  localparam int unsigned ReqW   = 3;
  localparam int unsigned PrioW  = 2;
  localparam int unsigned OpW    = 2;
  localparam int unsigned StatW  = 3;
  localparam int unsigned OccW   = 5;

  localparam logic [OpW-1:0] OpInsert = 2'd0;
  localparam logic [OpW-1:0] OpRemove = 2'd1;
  localparam logic [OpW-1:0] OpClear  = 2'd2;

  localparam logic [StatW-1:0] StInserted = 3'd0;
  localparam logic [StatW-1:0] StServed   = 3'd1;
  localparam logic [StatW-1:0] StEmpty    = 3'd2;
  localparam logic [StatW-1:0] StFull     = 3'd3;
  localparam logic [StatW-1:0] StInvalid  = 3'd4;
  localparam logic [StatW-1:0] StCleared  = 3'd5;

  localparam logic [ReqW-1:0] PrioMin = 3'd1;
  localparam logic [ReqW-1:0] PrioMax = 3'd3;

  typedef struct packed {
    logic [TagW-1:0]  tag;
    logic [AgeW-1:0]  age;
    logic [PrioW-1:0] prio;
  } entry_t;

  // Broadcast to every cell of the chain
  typedef struct packed {
    logic            insert;
    logic            remove;
    logic [ReqW-1:0] req_prio;
    entry_t          new_entry;
  } cell_ctrl_t;

  // Per-cell position relative to the fill count
  typedef struct packed {
    logic occupied;
    logic tail;
  } cell_pos_t;

endpackage

// ===== src/spq_if.sv =====
// Valid/ready channel interfaces for requests and results.
interface spq_in_if;
  logic                        valid;
  logic                        ready;
  logic [spq_pkg::OpW-1:0]     op;
  logic [spq_pkg::TagW-1:0]    patient_tag;
  logic [spq_pkg::AgeW-1:0]    age;
  logic [spq_pkg::ReqW-1:0]    priority_req;

  modport source (output valid, op, patient_tag, age, priority_req, input ready);
  modport sink   (input valid, op, patient_tag, age, priority_req, output ready);
endinterface

interface spq_out_if;
  logic                        valid;
  logic                        ready;
  logic [spq_pkg::StatW-1:0]   status;
  logic [spq_pkg::TagW-1:0]    out_tag;
  logic [spq_pkg::AgeW-1:0]    out_age;
  logic [spq_pkg::PrioW-1:0]   out_priority;
  logic [spq_pkg::OccW-1:0]    occupancy;

  modport source (output valid, status, out_tag, out_age, out_priority, occupancy,
                  input ready);
  modport sink   (input valid, status, out_tag, out_age, out_priority, occupancy,
                  output ready);
endinterface

// ===== src/spq_cell.sv =====
// One storage cell of the sorted chain: holds an entry, shifts left or right.
module spq_cell (
  input  logic                clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  spq_pkg::cell_pos_t  pos_i,
  input  spq_pkg::entry_t     left_entry_i,
  input  logic                left_greater_i,
  input  spq_pkg::entry_t     right_entry_i,
  output spq_pkg::entry_t     entry_o,
  output logic                greater_o
);

  spq_pkg::entry_t entry_q, entry_d;

  // Held entry is strictly less urgent than the request
  assign greater_o = pos_i.occupied &&
                     ({1'b0, entry_q.prio} > ctrl_i.req_prio);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert) begin
      if (left_greater_i) begin
        entry_d = left_entry_i;
      end else if (greater_o || pos_i.tail) begin
        entry_d = ctrl_i.new_entry;
      end
    end else if (ctrl_i.remove) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== src/stable_priority_queue_top.sv =====
// The result is registered at the accepting edge and offered from the next cycle.
// Throughput: one request per cycle; the whole cell chain compares and shifts
// in the accept cycle, and the output register frees as the result is taken.
// Reset: clears the fill count and the output valid; cell contents stay
// undefined and are only read below the fill count.
// Top level of the stable priority queue.
module stable_priority_queue_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  spq_in_if.sink     in_i,
  spq_out_if.source  out_o
);

  localparam int unsigned Depth  = spq_pkg::QueueDepth;
  localparam int unsigned CountW = spq_pkg::CountW;

  logic [CountW-1:0] count_q, count_d;
  logic              out_valid_q;
  logic [spq_pkg::StatW-1:0] status_q, status_d;
  spq_pkg::entry_t   res_q, res_d;
  logic [spq_pkg::OccW-1:0] occ_q;

  logic              accept;
  logic              prio_ok, full, empty;
  spq_pkg::cell_ctrl_t ctrl;

  spq_pkg::entry_t   cell_entry [Depth];
  logic              cell_greater [Depth];
  spq_pkg::cell_pos_t cell_pos [Depth];

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign prio_ok = (in_i.priority_req >= spq_pkg::PrioMin) &&
                   (in_i.priority_req <= spq_pkg::PrioMax);
  assign full    = (count_q == CountW'(Depth));
  assign empty   = (count_q == '0);

  always_comb begin
    ctrl                = '0;
    ctrl.req_prio       = in_i.priority_req;
    ctrl.new_entry.tag  = in_i.patient_tag;
    ctrl.new_entry.age  = in_i.age;
    ctrl.new_entry.prio = in_i.priority_req[spq_pkg::PrioW-1:0];
    ctrl.insert = accept && (in_i.op == spq_pkg::OpInsert) && prio_ok && !full;
    ctrl.remove = accept && (in_i.op == spq_pkg::OpRemove) && !empty;
  end

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    spq_pkg::entry_t left_entry, right_entry;
    logic            left_greater;

    assign cell_pos[i].occupied = (count_q > CountW'(i));
    assign cell_pos[i].tail     = (count_q == CountW'(i));

    if (i == 0) begin : g_head
      assign left_entry   = ctrl.new_entry;
      assign left_greater = 1'b0;
    end else begin : g_body
      assign left_entry   = cell_entry[i-1];
      assign left_greater = cell_greater[i-1];
    end

    if (i == Depth - 1) begin : g_last
      assign right_entry = cell_entry[i];
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk_i          (clk_i),
      .ctrl_i         (ctrl),
      .pos_i          (cell_pos[i]),
      .left_entry_i   (left_entry),
      .left_greater_i (left_greater),
      .right_entry_i  (right_entry),
      .entry_o        (cell_entry[i]),
      .greater_o      (cell_greater[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = spq_pkg::StInvalid;
    res_d    = '0;
    case (in_i.op)
      spq_pkg::OpInsert: begin
        if (!prio_ok) begin
          status_d = spq_pkg::StInvalid;
        end else if (full) begin
          status_d = spq_pkg::StFull;
        end else begin
          status_d = spq_pkg::StInserted;
          count_d  = count_q + 1'b1;
        end
      end
      spq_pkg::OpRemove: begin
        if (empty) begin
          status_d = spq_pkg::StEmpty;
        end else begin
          status_d = spq_pkg::StServed;
          res_d    = cell_entry[0];
          count_d  = count_q - 1'b1;
        end
      end
      spq_pkg::OpClear: begin
        status_d = spq_pkg::StCleared;
        count_d  = '0;
      end
      default: begin
        status_d = spq_pkg::StInvalid;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result payload until the transaction completes
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      res_q    <= res_d;
      occ_q    <= count_d[spq_pkg::OccW-1:0];
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = status_q;
  assign out_o.out_tag      = res_q.tag;
  assign out_o.out_age      = res_q.age;
  assign out_o.out_priority = res_q.prio;
  assign out_o.occupancy    = occ_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(Depth))
    else $error("fill count beyond depth");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_i.op == spq_pkg::OpClear) |=> (count_q == '0))
    else $error("clear left entries behind");

  a_serve_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.remove |=> out_valid_q && (status_q == spq_pkg::StServed) &&
                    (res_q.prio != '0))
    else $error("served entry missing or with null priority");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.insert |=> (count_q == $past(count_q) + 1'b1))
    else $error("insert did not grow the fill count");

  a_head_most_urgent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q > CountW'(1)) |-> (cell_entry[0].prio <= cell_entry[1].prio))
    else $error("head entry less urgent than its successor");
`endif

endmodule
